FILE: src/thed_pkg.sv
`default_nettype none

package thed_pkg;

    // Width of the internal time base; port timestamps are zero-extended to it.
    localparam int TIME_WIDTH = 64;
    // Width of the timestamp field on the ports.
    localparam int STAMP_W = 63;
    // A 16-bit millisecond count times one million fits in 36 bits.
    localparam int MS_W = 16;
    localparam int NS_W = 36;
    localparam int SUM_W = ((TIME_WIDTH > NS_W) ? TIME_WIDTH : NS_W) + 1;
    localparam int PROB_W = 18;
    localparam int LEVEL_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [NS_W-1:0] NS_PER_MS = NS_W'(1000000);
    localparam logic [LEVEL_W-1:0] P_ONE = LEVEL_W'(32768);

    localparam logic [LEVEL_W-1:0] ON_THR_RESET = LEVEL_W'(22938);
    localparam logic [LEVEL_W-1:0] OFF_THR_RESET = LEVEL_W'(9830);

    // Packed payload widths, rounded up to whole bytes.
    localparam int IN_BITS = STAMP_W + PROB_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + 1 + 1 + STAMP_W + STAMP_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [TIME_WIDTH-1:0] t_time;
    typedef logic [NS_W-1:0] t_span;
    typedef logic [LEVEL_W-1:0] t_level;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_COOLDOWN = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_THRESHOLD  = 3'd0,
        REG_OFF_THRESHOLD = 3'd1,
        REG_CONFIRM_MS    = 3'd2,
        REG_RELEASE_MS    = 3'd3,
        REG_HOLD_OFF_MS   = 3'd4
    } t_reg_index;

endpackage

`default_nettype wire

FILE: src/timed_hysteresis_event_detector_core.sv
`default_nettype none

// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid / s_axis_tready  now_time, probability
// m_axis      out  m_axis_tvalid / m_axis_tready  mode, started, ended, stamps
// cfg         in   i_cfg_valid / o_cfg_ready      register index, 16-bit value
//
// Every request passes from acceptance through the input register and then
// through the update logic into the result register. One request is accepted
// per cycle while the result is not stalled; the state update that links
// consecutive requests is combinational, between the two registers.
// Reset is synchronous and active low; it restores the register defaults and
// returns the detector to idle with all timers cleared. A stalled result holds
// the update stage, and the input register keeps one further request.

module timed_hysteresis_event_detector_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // tdata, from bit 0 up: now_time[62:0], probability[80:63], zero pad
    input  wire  [thed_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, from bit 0 up: mode[1:0], started[2], ended[3],
    // start_stamp[66:4], end_stamp[129:67], zero pad
    output logic [thed_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [thed_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [thed_pkg::LEVEL_W-1:0]        i_cfg_data
);

    // Configuration. The millisecond spans are converted to nanoseconds when
    // written, so the update path only compares against stored spans.
    thed_pkg::t_level r_on_thr;
    thed_pkg::t_level r_off_thr;
    thed_pkg::t_span  r_confirm_span;
    thed_pkg::t_span  r_release_span;
    thed_pkg::t_span  r_cool_span;
    thed_pkg::t_span  n_cfg_ns;

    assign o_cfg_ready = 1'b1;
    assign n_cfg_ns = thed_pkg::NS_W'(i_cfg_data) * thed_pkg::NS_PER_MS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_thr       <= thed_pkg::ON_THR_RESET;
            r_off_thr      <= thed_pkg::OFF_THR_RESET;
            r_confirm_span <= '0;
            r_release_span <= '0;
            r_cool_span    <= '0;
        end else if (i_cfg_valid) begin
            case (thed_pkg::t_reg_index'(i_cfg_index))
                thed_pkg::REG_ON_THRESHOLD:  r_on_thr       <= i_cfg_data;
                thed_pkg::REG_OFF_THRESHOLD: r_off_thr      <= i_cfg_data;
                thed_pkg::REG_CONFIRM_MS:    r_confirm_span <= n_cfg_ns;
                thed_pkg::REG_RELEASE_MS:    r_release_span <= n_cfg_ns;
                thed_pkg::REG_HOLD_OFF_MS:   r_cool_span    <= n_cfg_ns;
                default: ;
            endcase
        end
    end

    // Input register stage.
    logic                                r_in_valid;
    logic [thed_pkg::STAMP_W-1:0]        r_in_time;
    logic signed [thed_pkg::PROB_W-1:0]  r_in_prob;
    logic                                w_advance;

    // The update stage moves whenever the result register is free or drains.
    assign w_advance     = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_time <= s_axis_tdata[thed_pkg::STAMP_W-1:0];
            r_in_prob <= s_axis_tdata[thed_pkg::IN_BITS-1:thed_pkg::STAMP_W];
        end
    end

    // Detector state.
    thed_pkg::t_mode r_mode;
    thed_pkg::t_time r_above_since;
    thed_pkg::t_time r_below_since;
    thed_pkg::t_time r_cool_until;
    thed_pkg::t_time r_last_start;
    thed_pkg::t_time r_last_end;

    thed_pkg::t_mode n_mode;
    thed_pkg::t_time n_above_since;
    thed_pkg::t_time n_below_since;
    thed_pkg::t_time n_cool_until;
    thed_pkg::t_time n_last_start;
    thed_pkg::t_time n_last_end;
    logic            n_started;
    logic            n_ended;

    // Update datapath. Both timers are evaluated in parallel; the mode picks
    // which one takes effect.
    thed_pkg::t_time            w_now;
    thed_pkg::t_level           w_prob;
    thed_pkg::t_time            w_above_t0;
    thed_pkg::t_time            w_below_t0;
    thed_pkg::t_time            w_above_elapsed;
    thed_pkg::t_time            w_below_elapsed;
    logic                       w_confirm_done;
    logic                       w_release_done;
    logic [thed_pkg::SUM_W-1:0] w_cool_sum;
    thed_pkg::t_time            w_cool_deadline;

    assign w_now = thed_pkg::TIME_WIDTH'(r_in_time);

    // Negative probabilities clamp to zero, anything above one clamps to one.
    always_comb begin
        if (r_in_prob[thed_pkg::PROB_W-1]) begin
            w_prob = '0;
        end else if (r_in_prob > $signed(thed_pkg::PROB_W'(thed_pkg::P_ONE))) begin
            w_prob = thed_pkg::P_ONE;
        end else begin
            w_prob = r_in_prob[thed_pkg::LEVEL_W-1:0];
        end
    end

    // A timer start of zero means the timer is not running, so it starts now.
    assign w_above_t0 = (r_above_since == '0) ? w_now : r_above_since;
    assign w_below_t0 = (r_below_since == '0) ? w_now : r_below_since;
    assign w_above_elapsed = w_now - w_above_t0;
    assign w_below_elapsed = w_now - w_below_t0;
    // Time running backwards never expires a timer.
    assign w_confirm_done = (w_now >= w_above_t0)
                            && (w_above_elapsed >= thed_pkg::TIME_WIDTH'(r_confirm_span));
    assign w_release_done = (w_now >= w_below_t0)
                            && (w_below_elapsed >= thed_pkg::TIME_WIDTH'(r_release_span));

    // Cooldown deadline saturates at the largest representable time.
    assign w_cool_sum = thed_pkg::SUM_W'(w_now) + thed_pkg::SUM_W'(r_cool_span);
    assign w_cool_deadline = (w_cool_sum > thed_pkg::SUM_W'({thed_pkg::TIME_WIDTH{1'b1}}))
                             ? {thed_pkg::TIME_WIDTH{1'b1}}
                             : w_cool_sum[thed_pkg::TIME_WIDTH-1:0];

    always_comb begin
        n_mode        = r_mode;
        n_above_since = r_above_since;
        n_below_since = r_below_since;
        n_cool_until  = r_cool_until;
        n_last_start  = r_last_start;
        n_last_end    = r_last_end;
        n_started     = 1'b0;
        n_ended       = 1'b0;
        case (r_mode)
            thed_pkg::MODE_ACTIVE: begin
                if (w_prob <= r_off_thr) begin
                    n_below_since = w_below_t0;
                    if (w_release_done) begin
                        n_mode        = thed_pkg::MODE_COOLDOWN;
                        n_last_end    = w_now;
                        n_ended       = 1'b1;
                        n_cool_until  = w_cool_deadline;
                        n_below_since = '0;
                        n_above_since = '0;
                    end
                end else begin
                    n_below_since = '0;
                end
            end
            thed_pkg::MODE_COOLDOWN: begin
                if (w_now >= r_cool_until) begin
                    n_mode = thed_pkg::MODE_IDLE;
                end
            end
            thed_pkg::MODE_IDLE: begin
                // Samples are ignored until the cooldown deadline passes.
                if (w_now >= r_cool_until) begin
                    if (w_prob >= r_on_thr) begin
                        n_above_since = w_above_t0;
                        if (w_confirm_done) begin
                            n_mode        = thed_pkg::MODE_ACTIVE;
                            n_last_start  = w_now;
                            n_started     = 1'b1;
                            n_above_since = '0;
                            n_below_since = '0;
                        end
                    end else begin
                        n_above_since = '0;
                    end
                end
            end
            default: begin
                n_mode = thed_pkg::MODE_IDLE;
            end
        endcase
    end

    // State and result register.
    logic                         r_started;
    logic                         r_ended;
    logic [thed_pkg::STAMP_W-1:0] r_out_start;
    logic [thed_pkg::STAMP_W-1:0] r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= thed_pkg::MODE_IDLE;
            r_above_since <= '0;
            r_below_since <= '0;
            r_cool_until  <= '0;
            r_last_start  <= '0;
            r_last_end    <= '0;
            m_axis_tvalid <= 1'b0;
        end else if (w_advance) begin
            m_axis_tvalid <= r_in_valid;
            if (r_in_valid) begin
                r_mode        <= n_mode;
                r_above_since <= n_above_since;
                r_below_since <= n_below_since;
                r_cool_until  <= n_cool_until;
                r_last_start  <= n_last_start;
                r_last_end    <= n_last_end;
            end
        end
        if (w_advance && r_in_valid) begin
            r_started   <= n_started;
            r_ended     <= n_ended;
            r_out_start <= thed_pkg::STAMP_W'(n_last_start);
            r_out_end   <= thed_pkg::STAMP_W'(n_last_end);
        end
    end

    assign m_axis_tdata = thed_pkg::OUT_DATA_W'({r_out_end, r_out_start, r_ended,
                                                 r_started, r_mode});

    // An event cannot both start and end on the same request.
    a_start_end_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_started && r_ended))
        else $error("start and end flagged on one result");

    // A start flag always comes with the active mode, an end with cooldown.
    a_start_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_started) |-> (r_mode == thed_pkg::MODE_ACTIVE))
        else $error("start flagged outside active mode");

    a_end_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_ended) |-> (r_mode == thed_pkg::MODE_COOLDOWN))
        else $error("end flagged outside cooldown mode");

    // A stalled result freezes the detector state.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(r_mode) && $stable(r_last_start)))
        else $error("state changed while result stalled");

    // The confirm timer only runs in idle, the release timer only in active.
    a_timer_ownership: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_above_since != '0) |-> (r_mode == thed_pkg::MODE_IDLE)) and
        ((r_below_since != '0) |-> (r_mode == thed_pkg::MODE_ACTIVE)))
        else $error("timer running in the wrong mode");

endmodule

`default_nettype wire
